/* hw/rtl/ffa_pkg.sv */
// ffa_pkg: shared constants, table entry and result types for the first-fit allocator
// no dependencies; used by the interfaces and every allocator module but ffa_ram
package ffa_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int ADDR_BITS  = 16;
  localparam int SIZE_W     = ADDR_BITS + 1;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam logic [SIZE_W-1:0] HEAP_TOP = SIZE_W'(1) << ADDR_BITS;
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BLOCKS);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_BADFREE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MOVED   = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_W-1:0]    size;
    logic                 used;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] block_addr;
    logic [ADDR_BITS-1:0] moved_from;
    logic                 last;
  } res_t;

endpackage

/* hw/rtl/ffa_in_if.sv */
// ffa_in_if: request channel of the allocator, valid/ready with the request payload
// depends on ffa_pkg
interface ffa_in_if;
  import ffa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [SIZE_W-1:0]    request_bytes;
  logic [ADDR_BITS-1:0] release_addr;

  modport source (output valid, action, request_bytes, release_addr, input ready);
  modport sink   (input valid, action, request_bytes, release_addr, output ready);
endinterface

/* hw/rtl/ffa_out_if.sv */
// ffa_out_if: result channel of the allocator, valid/ready with the result payload
// depends on ffa_pkg
interface ffa_out_if;
  import ffa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [ADDR_BITS-1:0] block_addr;
  logic [ADDR_BITS-1:0] moved_from;
  logic                 last;

  modport source (output valid, status, block_addr, moved_from, last, input ready);
  modport sink   (input valid, status, block_addr, moved_from, last, output ready);
endinterface

/* hw/rtl/ffa_ram.sv */
// ffa_ram: generic single-write, single-read synchronous ram, registered read data
// no dependencies
module ffa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/ffa_ctrl.sv */
// ffa_ctrl: sequencer that scans, splits, merges and compacts the block table
// depends on ffa_pkg, ffa_in_if, ffa_out_if; drives the table ram ports
module ffa_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  ffa_in_if.sink                     in_ch,
  ffa_out_if.source                  out_ch,
  input  logic [ffa_pkg::SIZE_W-1:0] heap,
  input  logic                       cfg_load,
  output logic                       mem_we,
  output logic [ffa_pkg::IDX_W-1:0]  mem_waddr,
  output ffa_pkg::ent_t              mem_wdata,
  output logic [ffa_pkg::IDX_W-1:0]  mem_raddr,
  input  ffa_pkg::ent_t              mem_rdata
);
  import ffa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SCHK  = 4'd2;
  localparam logic [3:0] S_INS   = 4'd3;
  localparam logic [3:0] S_INSW  = 4'd4;
  localparam logic [3:0] S_INS2  = 4'd5;
  localparam logic [3:0] S_FR    = 4'd6;
  localparam logic [3:0] S_FRC   = 4'd7;
  localparam logic [3:0] S_FL    = 4'd8;
  localparam logic [3:0] S_FLC   = 4'd9;
  localparam logic [3:0] S_FW    = 4'd10;
  localparam logic [3:0] S_RM    = 4'd11;
  localparam logic [3:0] S_RMW   = 4'd12;
  localparam logic [3:0] S_CP    = 4'd13;
  localparam logic [3:0] S_CPC   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]           state_r, state_nxt, ret_r, ret_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, m_r, m_nxt;
  logic [IDX_W-1:0]     fit_r, fit_nxt;
  logic [SIZE_W-1:0]    pos_r, pos_nxt, req_r, req_nxt, rsize_r, rsize_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic                 act_r, act_nxt, comp_r, comp_nxt, init_r, init_nxt;
  logic                 rfree_r, rfree_nxt, lfree_r, lfree_nxt;
  logic [1:0]           d_r, d_nxt;
  ent_t                 cur_r, cur_nxt, lent_r, lent_nxt;
  res_t                 res_r, res_nxt, out_r, out_nxt;
  logic                 ov_r, ov_nxt;
  logic                 in_acc;

  // no item is taken in the cycle of a heap size write
  assign in_ch.ready       = (state_r == S_IDLE) && !init_r && !cfg_load;
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = ov_r;
  assign out_ch.status     = out_r.status;
  assign out_ch.block_addr = out_r.block_addr;
  assign out_ch.moved_from = out_r.moved_from;
  assign out_ch.last       = out_r.last;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;    cnt_nxt = cnt_r;   i_nxt = i_r;
    j_nxt = j_r;          k_nxt = k_r;        m_nxt = m_r;       fit_nxt = fit_r;
    pos_nxt = pos_r;      req_nxt = req_r;    rsize_nxt = rsize_r;
    addr_nxt = addr_r;    act_nxt = act_r;    comp_nxt = comp_r;
    init_nxt = init_r || cfg_load;
    rfree_nxt = rfree_r;  lfree_nxt = lfree_r; d_nxt = d_r;
    cur_nxt = cur_r;      lent_nxt = lent_r;  res_nxt = res_r;
    out_nxt = out_r;      ov_nxt = ov_r && !out_ch.ready;
    mem_we = 1'b0;        mem_waddr = '0;     mem_wdata = '0;
    mem_raddr = i_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (init_r) begin
          mem_we    = 1'b1;
          mem_wdata = '{start: '0, size: heap, used: 1'b0};
          cnt_nxt   = CNT_W'(1);
          init_nxt  = cfg_load;
        end else if (in_acc) begin
          act_nxt  = in_ch.action;
          req_nxt  = in_ch.request_bytes;
          addr_nxt = in_ch.release_addr;
          comp_nxt = 1'b0;
          i_nxt    = '0;
          if (in_ch.action == ACT_ALLOC && in_ch.request_bytes == '0) begin
            res_nxt   = '{status: ST_NOSPACE, block_addr: '0, moved_from: '0, last: 1'b1};
            ret_nxt   = S_IDLE;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (i_r == cnt_r) begin
          if (act_r == ACT_ALLOC && !comp_r) begin
            // nothing fits: slide used blocks down, then search again
            i_nxt = '0;  j_nxt = '0;  pos_nxt = '0;
            state_nxt = S_CP;
          end else begin
            res_nxt   = '{status: (act_r == ACT_FREE) ? ST_BADFREE : ST_NOSPACE,
                          block_addr: '0, moved_from: '0, last: 1'b1};
            ret_nxt   = S_IDLE;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        cur_nxt = mem_rdata;
        fit_nxt = i_r[IDX_W-1:0];
        i_nxt   = i_r + CNT_W'(1);
        state_nxt = S_SCAN;
        if (act_r == ACT_ALLOC) begin
          if (!mem_rdata.used && mem_rdata.size >= req_r) begin
            ret_nxt = S_IDLE;
            res_nxt = '{status: ST_OK, block_addr: mem_rdata.start, moved_from: '0,
                        last: 1'b1};
            if (mem_rdata.size == req_r) begin
              mem_we    = 1'b1;
              mem_waddr = i_r[IDX_W-1:0];
              mem_wdata = '{start: mem_rdata.start, size: mem_rdata.size, used: 1'b1};
              state_nxt = S_OUT;
            end else if (cnt_r == CNT_MAX) begin
              res_nxt.status     = ST_FULL;
              res_nxt.block_addr = '0;
              state_nxt = S_OUT;
            end else begin
              m_nxt     = cnt_r;
              state_nxt = S_INS;
            end
          end
        end else if (mem_rdata.used && mem_rdata.start == addr_r) begin
          state_nxt = S_FR;
        end
      end
      // open a hole above the split block, moving entries up one at a time
      S_INS: begin
        mem_raddr = IDX_W'(m_r - CNT_W'(1));
        if (m_r == CNT_W'(fit_r) + CNT_W'(1)) begin
          mem_we    = 1'b1;
          mem_waddr = fit_r;
          mem_wdata = '{start: cur_r.start, size: req_r, used: 1'b1};
          state_nxt = S_INS2;
        end else begin
          state_nxt = S_INSW;
        end
      end
      S_INSW: begin
        mem_we    = 1'b1;
        mem_waddr = m_r[IDX_W-1:0];
        mem_wdata = mem_rdata;
        m_nxt     = m_r - CNT_W'(1);
        state_nxt = S_INS;
      end
      S_INS2: begin
        mem_we    = 1'b1;
        mem_waddr = fit_r + IDX_W'(1);
        mem_wdata = '{start: ADDR_BITS'(SIZE_W'(cur_r.start) + req_r),
                      size: cur_r.size - req_r, used: 1'b0};
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_OUT;
      end
      S_FR: begin
        mem_raddr = fit_r + IDX_W'(1);
        rfree_nxt = 1'b0;
        state_nxt = (CNT_W'(fit_r) + CNT_W'(1) < cnt_r) ? S_FRC : S_FL;
      end
      S_FRC: begin
        rfree_nxt = !mem_rdata.used;
        rsize_nxt = mem_rdata.size;
        state_nxt = S_FL;
      end
      S_FL: begin
        mem_raddr = fit_r - IDX_W'(1);
        lfree_nxt = 1'b0;
        state_nxt = (fit_r != '0) ? S_FLC : S_FW;
      end
      S_FLC: begin
        lfree_nxt = !mem_rdata.used;
        lent_nxt  = mem_rdata;
        state_nxt = S_FW;
      end
      S_FW: begin
        mem_we    = 1'b1;
        mem_waddr = lfree_r ? fit_r - IDX_W'(1) : fit_r;
        mem_wdata = '{start: lfree_r ? lent_r.start : cur_r.start,
                      size: (lfree_r ? lent_r.size : '0) + cur_r.size
                            + (rfree_r ? rsize_r : '0),
                      used: 1'b0};
        k_nxt     = lfree_r ? CNT_W'(fit_r) : CNT_W'(fit_r) + CNT_W'(1);
        d_nxt     = 2'(lfree_r) + 2'(rfree_r);
        res_nxt   = '{status: ST_OK, block_addr: addr_r, moved_from: '0, last: 1'b1};
        ret_nxt   = S_IDLE;
        state_nxt = (lfree_r || rfree_r) ? S_RM : S_OUT;
      end
      // close the gap left by merged neighbours
      S_RM: begin
        mem_raddr = IDX_W'(k_r + CNT_W'(d_r));
        if (k_r + CNT_W'(d_r) >= cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(d_r);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RMW;
        end
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[IDX_W-1:0];
        mem_wdata = mem_rdata;
        k_nxt     = k_r + CNT_W'(1);
        state_nxt = S_RM;
      end
      S_CP: begin
        if (i_r == cnt_r) begin
          if (pos_r < heap && j_r < CNT_MAX) begin
            mem_we    = 1'b1;
            mem_waddr = j_r[IDX_W-1:0];
            mem_wdata = '{start: pos_r[ADDR_BITS-1:0], size: heap - pos_r, used: 1'b0};
            cnt_nxt   = j_r + CNT_W'(1);
          end else begin
            cnt_nxt   = j_r;
          end
          comp_nxt  = 1'b1;
          i_nxt     = '0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_CPC;
        end
      end
      S_CPC: begin
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_CP;
        if (mem_rdata.used) begin
          // write index never passes read index, so no forwarding needed
          mem_we    = 1'b1;
          mem_waddr = j_r[IDX_W-1:0];
          mem_wdata = '{start: pos_r[ADDR_BITS-1:0], size: mem_rdata.size, used: 1'b1};
          j_nxt     = j_r + CNT_W'(1);
          pos_nxt   = pos_r + mem_rdata.size;
          if (SIZE_W'(mem_rdata.start) != pos_r) begin
            res_nxt   = '{status: ST_MOVED, block_addr: pos_r[ADDR_BITS-1:0],
                          moved_from: mem_rdata.start, last: 1'b0};
            ret_nxt   = S_CP;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          out_nxt   = res_r;
          ov_nxt    = 1'b1;
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      cnt_r   <= CNT_W'(1);
      init_r  <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cnt_r   <= cnt_nxt;
      init_r  <= init_nxt;
      ov_r    <= ov_nxt;
    end
    i_r <= i_nxt;  j_r <= j_nxt;  k_r <= k_nxt;  m_r <= m_nxt;  fit_r <= fit_nxt;
    pos_r <= pos_nxt;  req_r <= req_nxt;  rsize_r <= rsize_nxt;  addr_r <= addr_nxt;
    act_r <= act_nxt;  comp_r <= comp_nxt;  rfree_r <= rfree_nxt;  lfree_r <= lfree_nxt;
    d_r <= d_nxt;  cur_r <= cur_nxt;  lent_r <= lent_nxt;  res_r <= res_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && cnt_r <= CNT_MAX)
    else $error("block count out of range");
  a_moved_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_r.last |-> out_r.status == ST_MOVED)
    else $error("non-final result that is not a moved block");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("new item taken while one is in progress");
  a_idle_write_init: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && state_r == S_IDLE |-> init_r && mem_waddr == '0)
    else $error("table written while idle without reinitialise");
`endif
endmodule

/* hw/rtl/first_fit_allocator_coalesce_compact.sv */
// First-fit heap allocator with coalescing and compaction. The block table (start, size,
// used) lives in a synchronous ram of MAX_BLOCKS entries with one write and one read port;
// one item is worked on at a time. Each table step is a read and, in the cycle after, a use
// or write-back. An item scans the entries, then shifts entries on a split or merge; an
// allocate that compacts adds a pass that slides used blocks down, one result per moved
// block and a second scan. Output stalls hold up the item in progress.
// After reset, and after each heap size write on cfg_we, entry zero is rewritten before the
// next item is taken; no item is taken in the cycle of the write itself.
module first_fit_allocator_coalesce_compact (
  input  logic                       clk,
  input  logic                       rst_n,
  ffa_in_if.sink                     in_ch,
  ffa_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [ffa_pkg::SIZE_W-1:0] cfg_wdata
);
  import ffa_pkg::*;

  logic [SIZE_W-1:0] heap_r, heap_nxt;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  ent_t              mem_wdata, mem_rdata;
  logic [ENT_W-1:0]  rdata_raw;

  // clamp the heap size to one byte at least and the address space at most
  always_comb begin
    heap_nxt = heap_r;
    if (cfg_we) begin
      priority if (cfg_wdata == '0)      heap_nxt = SIZE_W'(1);
      else if (cfg_wdata > HEAP_TOP)     heap_nxt = HEAP_TOP;
      else                               heap_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= HEAP_TOP;
    end else begin
      heap_r <= heap_nxt;
    end
  end

  assign mem_rdata = ent_t'(rdata_raw);

  ffa_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(ENT_W)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata_raw)
  );

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .heap      (heap_r),
    .cfg_load  (cfg_we),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );
endmodule

/* tb/sv/heap_checker.sv */
// heap_checker: watches the request, result and heap size ports of the allocator,
// keeps its own block table and compares every result item
// depends on ffa_pkg and the channel interfaces
`timescale 1ns / 100ps
module heap_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  ffa_in_if                          in_ch,
  ffa_out_if                         out_ch,
  input  logic                       cfg_we,
  input  logic [ffa_pkg::SIZE_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);
  import ffa_pkg::*;

  int   heap_sz;
  int   blk_start [MAX_BLOCKS];
  int   blk_size  [MAX_BLOCKS];
  bit   blk_used  [MAX_BLOCKS];
  int   blk_cnt;
  res_t result_q [$];

  function automatic int clamp_heap(int v);
    if (v == 0) return 1;
    return (v > int'(HEAP_TOP)) ? int'(HEAP_TOP) : v;
  endfunction

  task automatic table_clear();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_start[i] = 0;
      blk_size[i]  = 0;
      blk_used[i]  = 0;
    end
    blk_size[0] = heap_sz;
    blk_cnt = 1;
  endtask

  task automatic add_result(logic [2:0] st, int addr, int from, logic fin);
    res_t r;
    r.status     = st;
    r.block_addr = addr[ADDR_BITS-1:0];
    r.moved_from = from[ADDR_BITS-1:0];
    r.last       = fin;
    result_q = {result_q, r};
  endtask

  function automatic int first_fit(int n);
    for (int i = 0; i < blk_cnt; i++)
      if (!blk_used[i] && blk_size[i] >= n) return i;
    return -1;
  endfunction

  task automatic drop_entry(int i);
    for (int k = i; k + 1 < blk_cnt; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k]  = blk_size[k+1];
      blk_used[k]  = blk_used[k+1];
    end
    blk_cnt--;
  endtask

  task automatic slide_down();
    int pos;
    int j;
    int sz;
    pos = 0;
    j = 0;
    for (int i = 0; i < blk_cnt; i++) begin
      if (blk_used[i]) begin
        sz = blk_size[i];
        if (blk_start[i] != pos) add_result(ST_MOVED, pos, blk_start[i], 1'b0);
        blk_start[j] = pos;
        blk_size[j]  = sz;
        blk_used[j]  = 1;
        pos += sz;
        j++;
      end
    end
    if (pos < heap_sz && j < MAX_BLOCKS) begin
      blk_start[j] = pos;
      blk_size[j]  = heap_sz - pos;
      blk_used[j]  = 0;
      j++;
    end
    blk_cnt = j;
  endtask

  task automatic predict_alloc(int n);
    int f;
    int old;
    if (n == 0) begin
      add_result(ST_NOSPACE, 0, 0, 1'b1);
      return;
    end
    f = first_fit(n);
    if (f < 0) begin
      slide_down();
      f = first_fit(n);
      if (f < 0) begin
        add_result(ST_NOSPACE, 0, 0, 1'b1);
        return;
      end
    end
    if (blk_size[f] == n) begin
      blk_used[f] = 1;
      add_result(ST_OK, blk_start[f], 0, 1'b1);
      return;
    end
    if (blk_cnt >= MAX_BLOCKS) begin
      add_result(ST_FULL, 0, 0, 1'b1);
      return;
    end
    for (int m = blk_cnt; m > f + 1; m--) begin
      blk_start[m] = blk_start[m-1];
      blk_size[m]  = blk_size[m-1];
      blk_used[m]  = blk_used[m-1];
    end
    old = blk_size[f];
    blk_size[f]    = n;
    blk_used[f]    = 1;
    blk_start[f+1] = blk_start[f] + n;
    blk_size[f+1]  = old - n;
    blk_used[f+1]  = 0;
    blk_cnt++;
    add_result(ST_OK, blk_start[f], 0, 1'b1);
  endtask

  task automatic predict_free(int addr);
    int i;
    for (i = 0; i < blk_cnt; i++)
      if (blk_start[i] == addr && blk_used[i]) break;
    if (i >= blk_cnt) begin
      add_result(ST_BADFREE, 0, 0, 1'b1);
      return;
    end
    blk_used[i] = 0;
    if (i + 1 < blk_cnt && !blk_used[i+1]) begin
      blk_size[i] += blk_size[i+1];
      drop_entry(i + 1);
    end
    if (i > 0 && !blk_used[i-1]) begin
      blk_size[i-1] += blk_size[i];
      drop_entry(i);
    end
    add_result(ST_OK, addr, 0, 1'b1);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      heap_sz = clamp_heap(int'(HEAP_TOP));
      table_clear();
      result_q.delete();
      fail_count = 0;
    end else begin
      // results first: they always belong to items taken earlier
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result item st=%0d addr=%0d from=%0d last=%0b",
                     $realtime, out_ch.status, out_ch.block_addr, out_ch.moved_from,
                     out_ch.last);
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.status || out_ch.block_addr !== want.block_addr ||
              out_ch.moved_from !== want.moved_from || out_ch.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch exp st=%0d addr=%0d from=%0d last=%0b",
                       $realtime, want.status, want.block_addr, want.moved_from,
                       want.last);
              $display("%0t:                 got st=%0d addr=%0d from=%0d last=%0b",
                       $realtime, out_ch.status, out_ch.block_addr, out_ch.moved_from,
                       out_ch.last);
            end
          end
        end
      end
      if (cfg_we) begin
        heap_sz = clamp_heap(int'(cfg_wdata));
        table_clear();
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_ALLOC) predict_alloc(int'(in_ch.request_bytes));
        else predict_free(int'(in_ch.release_addr));
      end
    end
    pending = result_q.size();
  end
endmodule

/* tb/sv/tb_top.sv */
// tb_top: clock, reset and stimulus for the first-fit allocator, with heap_checker beside it
// depends on ffa_pkg, the channel interfaces, the allocator and heap_checker
`timescale 1ns / 100ps
module tb_top;
  import ffa_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  int                cycle_cnt;
  int                burst_left;
  bit                hold_req;
  int                heap_now;

  ffa_in_if  in_ch ();
  ffa_out_if out_ch ();

  first_fit_allocator_coalesce_compact DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  heap_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > 1000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: stall pattern of its own, long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (cycle_cnt[8]) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic offer(logic act, int req, int rel);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid         = 1'b1;
    in_ch.action        = act;
    in_ch.request_bytes = req[SIZE_W-1:0];
    in_ch.release_addr  = rel[ADDR_BITS-1:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_heap(int v);
    drain();
    repeat (300) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v[SIZE_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    heap_now = (v == 0) ? 1 : ((v > 65536) ? 65536 : v);
  endtask

  // mostly aligned sizes and frees at aligned addresses, so frees often hit live blocks
  task automatic random_items(int n, int grain);
    int sz;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: offer(ACT_FREE, $urandom, $urandom);
        1: offer(ACT_ALLOC, $urandom_range(0, 131071), $urandom);
        2, 3, 4: begin
          offer(ACT_FREE, $urandom, grain * $urandom_range(0, heap_now / grain));
        end
        default: begin
          sz = grain * $urandom_range(1, 6);
          offer(ACT_ALLOC, sz, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.release_addr = '0;
    cycle_cnt = 0;
    burst_left = 0;
    hold_req = 1'b0;
    heap_now = 65536;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset heap: zero request, whole heap, bad frees, oversize request, then small blocks and a compaction
    offer(ACT_ALLOC, 0, 0);
    offer(ACT_ALLOC, 65536, 0);
    offer(ACT_FREE, 0, 65535);
    offer(ACT_FREE, 0, 0);
    offer(ACT_FREE, 0, 0);
    offer(ACT_ALLOC, 131071, 0);
    offer(ACT_ALLOC, 100, 0);
    offer(ACT_ALLOC, 200, 0);
    offer(ACT_ALLOC, 300, 0);
    offer(ACT_FREE, 0, 100);
    offer(ACT_FREE, 0, 0);
    offer(ACT_ALLOC, 65300, 0);
    offer(ACT_ALLOC, 1, 0);

    // fill the table with one-byte blocks, then a split with the table full, alternate frees and one more allocation
    set_heap(40);
    for (int k = 0; k < 32; k++) offer(ACT_ALLOC, 1, 0);
    offer(ACT_ALLOC, 8, 0);
    for (int k = 0; k < 31; k += 2) offer(ACT_FREE, 0, k);
    offer(ACT_ALLOC, 9, 0);

    // heap of one byte via a zero write
    set_heap(0);
    offer(ACT_ALLOC, 2, 0);
    offer(ACT_ALLOC, 1, 0);
    offer(ACT_FREE, 0, 0);

    set_heap(256);
    random_items(12, 8);
    hold_req = 1'b1;
    random_items(8, 8);
    drain();
    random_items(10, 8);

    set_heap(131071);
    random_items(8, 4096);

    drain();
    repeat (300) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_in_if.sv
hw/rtl/ffa_out_if.sv
hw/rtl/ffa_ram.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/first_fit_allocator_coalesce_compact.sv
tb/sv/heap_checker.sv
tb/sv/tb_top.sv
